// ===== hdl/sparse_column_run_encoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Sparse column run encoder: assertion macros
// Shared property wrappers, clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COLUMN_RUN_ENCODER_TOP_DEFINES_SVH
`define SPARSE_COLUMN_RUN_ENCODER_TOP_DEFINES_SVH

// same-cycle implication
`define SCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sce: implication check failed");

// next-cycle implication
`define SCE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sce: next-cycle check failed");

`endif

// ===== hdl/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse column run encoder package
// Field widths, reset constants and the types shared between modules.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int ROW_INDEX_W   = 32;
    localparam int ENTRY_VALUE_W = 64;
    localparam int ROW_COUNT_W   = 32;
    localparam int RUN_VALUE_W   = 64;
    localparam int RUN_LENGTH_W  = 32;
    localparam int RUN_START_W   = 32;
    localparam int RUN_NUMBER_W  = 32;

    localparam int IN_TDATA_W  = ROW_INDEX_W + ENTRY_VALUE_W;
    localparam int OUT_TDATA_W = RUN_VALUE_W + RUN_LENGTH_W + RUN_START_W + RUN_NUMBER_W;

    localparam logic [ROW_COUNT_W-1:0] RESET_ROW_COUNT = 32'd1024;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // one result beat
    typedef struct packed {
        logic [RUN_NUMBER_W-1:0] number;
        logic [RUN_START_W-1:0]  start;
        logic [RUN_LENGTH_W-1:0] length;
        logic [RUN_VALUE_W-1:0]  value;
        logic                    first;
        logic                    last;
    } t_run;

endpackage

// ===== hdl/sce_front.sv =====
// ----------------------------------------------------------------------------
// Sparse column run encoder: front end
// Classifies each entry into up to three runs and tracks column state.
// ----------------------------------------------------------------------------
module sce_front #(
    parameter int ROW_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sce_pkg::ROW_COUNT_W-1:0]   i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [sce_pkg::ROW_INDEX_W-1:0]   i_row_index,
    input  logic [sce_pkg::ENTRY_VALUE_W-1:0] i_entry_value,
    input  logic                              i_column_end,
    input  logic                              i_empty_column,
    input  sce_pkg::t_q_stat                  i_q_stat,
    output logic                              o_push,
    output logic [4+VALUE_BITS+6*ROW_BITS-1:0] o_job
);
    import sce_pkg::*;

    typedef struct packed {
        logic                  pre_valid;
        logic                  pre_first;
        logic [ROW_BITS-1:0]   pre_len;
        logic [ROW_BITS-1:0]   pre_start;
        logic [VALUE_BITS-1:0] main_value;
        logic [ROW_BITS-1:0]   main_len;
        logic [ROW_BITS-1:0]   main_start;
        logic                  main_first;
        logic                  post_valid;
        logic [ROW_BITS-1:0]   post_len;
        logic [ROW_BITS-1:0]   post_start;
    } t_job;

    logic [ROW_BITS-1:0] r_row_count;
    logic [ROW_BITS-1:0] r_prev_row;
    logic                r_started;

    logic [ROW_BITS-1:0] row;
    logic [ROW_BITS:0]   row_x;
    logic [ROW_BITS:0]   prev_inc;
    logic [ROW_BITS:0]   row_inc;
    logic [ROW_BITS:0]   cnt_x;
    logic                lead;
    logic                gap;
    logic                trail;
    t_job                job;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    assign row      = i_row_index[ROW_BITS-1:0];
    assign row_x    = {1'b0, row};
    assign prev_inc = {1'b0, r_prev_row} + (ROW_BITS+1)'(1);
    assign row_inc  = row_x + (ROW_BITS+1)'(1);
    assign cnt_x    = {1'b0, r_row_count};

    // leading zeros before the first entry, a hole between entries, or trailing zeros
    assign lead  = !r_started && (row != '0);
    assign gap   = r_started && (row_x > prev_inc);
    assign trail = i_column_end && (row_inc < cnt_x);

    always_comb begin
        job = '0;
        if (i_empty_column) begin
            job.main_len   = r_row_count;
            job.main_first = 1'b1;
        end else begin
            job.pre_valid  = lead || gap;
            job.pre_first  = lead;
            job.pre_len    = lead ? row : (row - prev_inc[ROW_BITS-1:0]);
            job.pre_start  = lead ? '0 : prev_inc[ROW_BITS-1:0];
            job.main_value = i_entry_value[VALUE_BITS-1:0];
            job.main_len   = ROW_BITS'(1);
            job.main_start = row;
            job.main_first = !r_started && (row == '0);
            job.post_valid = trail;
            job.post_len   = r_row_count - row_inc[ROW_BITS-1:0];
            job.post_start = row_inc[ROW_BITS-1:0];
        end
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_BITS'(RESET_ROW_COUNT);
            r_prev_row  <= '0;
            r_started   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_row_count <= i_cfg_wdata[ROW_BITS-1:0];
            end
            if (o_push) begin
                if (i_empty_column) begin
                    r_prev_row <= '0;
                    r_started  <= 1'b0;
                end else begin
                    r_prev_row <= row;
                    r_started  <= !i_column_end;
                end
            end
        end
    end

endmodule

// ===== hdl/sce_queue.sv =====
// ----------------------------------------------------------------------------
// Sparse column run encoder: job queue
// Small register queue between front and back end.
// ----------------------------------------------------------------------------
module sce_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output sce_pkg::t_q_stat o_stat
);
    import sce_pkg::*;

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== hdl/sce_back.sv =====
// ----------------------------------------------------------------------------
// Sparse column run encoder: back end
// Walks the head job's runs, one beat per cycle unless stalled, and numbers them.
// ----------------------------------------------------------------------------
module sce_back #(
    parameter int ROW_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [4+VALUE_BITS+6*ROW_BITS-1:0] i_job,
    input  sce_pkg::t_q_stat                   i_q_stat,
    output logic                               o_pop,
    input  logic                               i_ready,
    output logic                               o_valid,
    output sce_pkg::t_run                      o_run
);
    import sce_pkg::*;

    typedef struct packed {
        logic                  pre_valid;
        logic                  pre_first;
        logic [ROW_BITS-1:0]   pre_len;
        logic [ROW_BITS-1:0]   pre_start;
        logic [VALUE_BITS-1:0] main_value;
        logic [ROW_BITS-1:0]   main_len;
        logic [ROW_BITS-1:0]   main_start;
        logic                  main_first;
        logic                  post_valid;
        logic [ROW_BITS-1:0]   post_len;
        logic [ROW_BITS-1:0]   post_start;
    } t_job;

    typedef enum logic [2:0] {
        PH_PRE  = 3'b001,
        PH_MAIN = 3'b010,
        PH_POST = 3'b100
    } t_phase;

    t_job                    job;
    t_phase                  r_phase;
    t_phase                  n_phase;
    logic                    r_out_valid;
    t_run                    r_run;
    logic [RUN_NUMBER_W-1:0] r_run_counter;

    logic                  emit;
    logic [VALUE_BITS-1:0] sel_value;
    logic [ROW_BITS-1:0]   sel_len;
    logic [ROW_BITS-1:0]   sel_start;
    logic                  sel_first;
    logic                  sel_last;

    assign job  = i_job;
    assign emit = !i_q_stat.empty && (!r_out_valid || i_ready);

    // main run by default; the pre run is skipped in place when absent
    always_comb begin
        sel_value = job.main_value;
        sel_len   = job.main_len;
        sel_start = job.main_start;
        sel_first = job.main_first;
        sel_last  = !job.post_valid;
        n_phase   = job.post_valid ? PH_POST : PH_PRE;
        unique case (r_phase)
            PH_PRE: begin
                if (job.pre_valid) begin
                    sel_value = '0;
                    sel_len   = job.pre_len;
                    sel_start = job.pre_start;
                    sel_first = job.pre_first;
                    sel_last  = 1'b0;
                    n_phase   = PH_MAIN;
                end
            end
            PH_MAIN: begin
            end
            PH_POST: begin
                sel_value = '0;
                sel_len   = job.post_len;
                sel_start = job.post_start;
                sel_first = 1'b0;
                sel_last  = 1'b1;
                n_phase   = PH_PRE;
            end
            default: begin
            end
        endcase
    end

    assign o_pop   = emit && sel_last;
    assign o_valid = r_out_valid;
    assign o_run   = r_run;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_run.value  <= RUN_VALUE_W'(sel_value);
            r_run.length <= RUN_LENGTH_W'(sel_len);
            r_run.start  <= RUN_START_W'(sel_start);
            r_run.first  <= sel_first;
            r_run.last   <= sel_last;
            r_run.number <= r_run_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_PRE;
            r_out_valid   <= 1'b0;
            r_run_counter <= '0;
        end else begin
            if (emit) begin
                r_phase       <= n_phase;
                r_out_valid   <= 1'b1;
                r_run_counter <= r_run_counter + RUN_NUMBER_W'(1);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/sparse_column_run_encoder_top.sv =====
// Path: an entry's job is registered in the job queue, its runs in the output register.
// Throughput: one input beat per cycle into a 4-deep job queue while it is not full;
//   the result port moves one run per cycle while the receiver is ready.
// Reset: synchronous, active low; clears queue, column state and run counter,
//   and sets row_count to 1024. No clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
// Sparse column run encoder, top level
// Turns the nonzero entries of sparse matrix columns into numbered runs.
// ----------------------------------------------------------------------------
`include "sparse_column_run_encoder_top_defines.svh"

module sparse_column_run_encoder_top #(
    parameter int ROW_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // row_count register
    input  logic                            i_cfg_we,
    input  logic [sce_pkg::ROW_COUNT_W-1:0] i_cfg_wdata,
    // entry beats
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [sce_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // row_index, entry_value
    input  logic                            i_s_axis_tlast,  // column_end
    input  logic                            i_s_axis_tuser,  // empty_column
    // run beats
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [sce_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,  // value, length, start, number
    output logic                            o_m_axis_tlast,  // last_of_item
    output logic                            o_m_axis_tuser   // column_first
);
    import sce_pkg::*;

    localparam int JOB_W = 4 + VALUE_BITS + 6 * ROW_BITS;

    // Front end: classifies an entry into (optional) leading/gap zero run,
    // the value run and (optional) trailing zero run, all combinationally, and
    // hands that job to the queue. Column state updates on the input beat.
    // Back end: walks the head job's runs one beat per cycle while not stalled into a
    // single output register, so a stalled result never blocks the input side
    // until the queue fills.

    logic             push;
    logic             pop;
    logic [JOB_W-1:0] front_job;
    logic [JOB_W-1:0] head_job;
    t_q_stat          q_stat;
    t_run             run;

    // assertion helpers
    logic                    out_beat;
    logic                    back_free;
    logic                    first_value;
    logic [RUN_NUMBER_W-1:0] num_next;

    sce_front #(
        .ROW_BITS   (ROW_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_row_index    (i_s_axis_tdata[ROW_INDEX_W-1:0]),
        .i_entry_value  (i_s_axis_tdata[IN_TDATA_W-1:ROW_INDEX_W]),
        .i_column_end   (i_s_axis_tlast),
        .i_empty_column (i_s_axis_tuser),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_job          (front_job)
    );

    sce_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_stat  (q_stat)
    );

    sce_back #(
        .ROW_BITS   (ROW_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_run    (run)
    );

    // low bits first: value, length, start row, run number
    assign o_m_axis_tdata = {run.number, run.start, run.length, run.value};
    assign o_m_axis_tlast = run.last;
    assign o_m_axis_tuser = run.first;

    assign out_beat    = o_m_axis_tvalid && i_m_axis_tready;
    assign back_free   = !q_stat.empty && (!o_m_axis_tvalid || i_m_axis_tready);
    assign first_value = o_m_axis_tvalid && o_m_axis_tuser && (run.value != '0);
    assign num_next    = run.number + RUN_NUMBER_W'(1);

    // a column-first run carrying a nonzero value is always a single row
    `SCE_ASSERT_IMP(a_first_value_len1, first_value, run.length == RUN_LENGTH_W'(1))
    // pending job and a free output slot must give a beat next cycle
    `SCE_ASSERT_NXT(a_back_progress, back_free, o_m_axis_tvalid)
    // run numbers step by one from beat to beat
    `SCE_ASSERT_NXT(a_run_num_step, out_beat, !o_m_axis_tvalid || (run.number == $past(num_next)))

endmodule
